### hw/rtl/chunk_lru_tag_tracker_defines.svh
// Assertion macros shared by the chunk LRU tag tracker RTL.
`ifndef CHUNK_LRU_TAG_TRACKER_DEFINES_SVH
`define CHUNK_LRU_TAG_TRACKER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CLT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("chunk_lru_tag_tracker: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define CLT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("chunk_lru_tag_tracker: next-cycle check failed");

`endif

### hw/rtl/clt_pkg.sv
// Shared widths and defaults for the chunk LRU tag tracker.
`default_nettype none

package clt_pkg;

    localparam int KEY_W   = 63;
    localparam int TAG_W   = 43;
    localparam int COUNT_W = 4;
    localparam int HALF_W  = 32;
    localparam int RECIP_W = 64;
    localparam int PROD_W  = 128;

    localparam longint unsigned CHUNK_SIZE_DEFAULT = 64'd2000000;
    localparam int              SLOTS_DEFAULT      = 8;

endpackage

`default_nettype wire

### hw/rtl/chunk_lru_tag_tracker.sv
// Chunk LRU tag tracker: constant divide pipeline and fully associative recency store.
//
//  channel | ports                                   | direction | role
//  --------+-----------------------------------------+-----------+---------------------------
//  s_      | s_valid s_ready s_key                   | in        | key lookup requests
//  m_      | m_valid m_ready m_chunk_index m_hit     | out       | one result per request
//          | m_evict_valid m_evicted_index           |           |
//          | m_resident_count                        |           |
//
//  One transaction per cycle sustained while m_ready stays high.
//  The reciprocal multiply registers key, partial products, partial sums and the final
//  add and shift; the combinational recency update then feeds the result register.
//  aresetn (synchronous) clears stage valid bits and occupancy; no clearing pass is needed.
//  m_ready low holds the result; stages keep filling until all are full, then s_ready falls.
`default_nettype none

`include "chunk_lru_tag_tracker_defines.svh"

module chunk_lru_tag_tracker #(
    parameter longint unsigned CHUNK_SIZE = clt_pkg::CHUNK_SIZE_DEFAULT,
    parameter int              SLOTS      = clt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [clt_pkg::KEY_W-1:0]  s_key,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [clt_pkg::TAG_W-1:0]       m_chunk_index,
    output logic                            m_hit,
    output logic                            m_evict_valid,
    output logic [clt_pkg::TAG_W-1:0]       m_evicted_index,
    output logic [clt_pkg::COUNT_W-1:0]     m_resident_count
);

    localparam int OCC_W   = $clog2(SLOTS + 1);
    localparam int OCC_X_W = (OCC_W > clt_pkg::COUNT_W) ? OCC_W : clt_pkg::COUNT_W;
    localparam int RSHIFT  = clt_pkg::KEY_W + $clog2(CHUNK_SIZE);
    localparam int HI_W    = clt_pkg::KEY_W - clt_pkg::HALF_W;
    localparam int A_W     = 2 * clt_pkg::HALF_W + clt_pkg::HALF_W + 1;
    localparam int B_W     = clt_pkg::PROD_W - 1;

    localparam logic [clt_pkg::PROD_W-1:0] RECIP_FULL =
        ((clt_pkg::PROD_W'(1) << RSHIFT) + clt_pkg::PROD_W'(CHUNK_SIZE) - clt_pkg::PROD_W'(1))
        / clt_pkg::PROD_W'(CHUNK_SIZE);
    localparam logic [clt_pkg::RECIP_W-1:0] RECIP    = RECIP_FULL[clt_pkg::RECIP_W-1:0];
    localparam logic [clt_pkg::HALF_W-1:0]  RECIP_LO = RECIP[clt_pkg::HALF_W-1:0];
    localparam logic [clt_pkg::HALF_W-1:0]  RECIP_HI = RECIP[clt_pkg::RECIP_W-1:clt_pkg::HALF_W];

    // pipeline control
    logic v0_reg, v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic out_free, free3, free2, free1, free0;
    logic ld0, ld1, ld2, ld3, ld4;

    // datapath
    logic [clt_pkg::KEY_W-1:0]    key_reg;
    logic [2*clt_pkg::HALF_W-1:0] p_ll_reg, p_lh_reg, p_ll_next, p_lh_next;
    logic [HI_W+clt_pkg::HALF_W-1:0] p_hl_reg, p_hh_reg, p_hl_next, p_hh_next;
    logic [A_W-1:0]               a_reg, a_next;
    logic [B_W-1:0]               b_reg, b_next;
    logic [clt_pkg::PROD_W-1:0]   sum_full, quot_full;
    logic [clt_pkg::TAG_W-1:0]    tag_reg, tag_next;

    // recency store
    logic [clt_pkg::TAG_W-1:0] tags_reg  [SLOTS];
    logic [clt_pkg::TAG_W-1:0] tags_next [SLOTS];
    logic [clt_pkg::TAG_W-1:0] tag_up    [SLOTS];
    logic [OCC_W-1:0]          occ_reg, occ_next;
    logic [OCC_X_W-1:0]        occ_ext;
    logic [SLOTS-1:0]          match, at_or_above_hit;
    logic [SLOTS-1:0]          shifted;
    logic                      lru_hit, lru_full;
    logic [clt_pkg::TAG_W-1:0] evicted;

    logic [clt_pkg::TAG_W-1:0]   m_chunk_index_reg, m_evicted_index_reg;
    logic                        m_hit_reg, m_evict_valid_reg;
    logic [clt_pkg::COUNT_W-1:0] m_resident_count_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign ld4      = v3_reg && out_free;
    assign free3    = !v3_reg || out_free;
    assign ld3      = v2_reg && free3;
    assign free2    = !v2_reg || free3;
    assign ld2      = v1_reg && free2;
    assign free1    = !v1_reg || free2;
    assign ld1      = v0_reg && free1;
    assign free0    = !v0_reg || free1;
    assign ld0      = s_valid && free0;
    assign s_ready  = free0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v0_reg      <= ld0 || (v0_reg && !ld1);
            v1_reg      <= ld1 || (v1_reg && !ld2);
            v2_reg      <= ld2 || (v2_reg && !ld3);
            v3_reg      <= ld3 || (v3_reg && !ld4);
            m_valid_reg <= ld4 || (m_valid_reg && !m_ready);
        end
    end

    // partial products of key times reciprocal
    assign p_ll_next = (2*clt_pkg::HALF_W)'(key_reg[clt_pkg::HALF_W-1:0])
                     * (2*clt_pkg::HALF_W)'(RECIP_LO);
    assign p_lh_next = (2*clt_pkg::HALF_W)'(key_reg[clt_pkg::HALF_W-1:0])
                     * (2*clt_pkg::HALF_W)'(RECIP_HI);
    assign p_hl_next = (HI_W+clt_pkg::HALF_W)'(key_reg[clt_pkg::KEY_W-1:clt_pkg::HALF_W])
                     * (HI_W+clt_pkg::HALF_W)'(RECIP_LO);
    assign p_hh_next = (HI_W+clt_pkg::HALF_W)'(key_reg[clt_pkg::KEY_W-1:clt_pkg::HALF_W])
                     * (HI_W+clt_pkg::HALF_W)'(RECIP_HI);

    assign a_next = A_W'(p_ll_reg) + A_W'({p_lh_reg, {clt_pkg::HALF_W{1'b0}}});
    assign b_next = B_W'({p_hh_reg, {(2*clt_pkg::HALF_W){1'b0}}})
                  + B_W'({p_hl_reg, {clt_pkg::HALF_W{1'b0}}});

    assign sum_full  = clt_pkg::PROD_W'(a_reg) + clt_pkg::PROD_W'(b_reg);
    assign quot_full = sum_full >> RSHIFT;
    assign tag_next  = quot_full[clt_pkg::TAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (ld0) begin
            key_reg <= s_key;
        end
        if (ld1) begin
            p_ll_reg <= p_ll_next;
            p_lh_reg <= p_lh_next;
            p_hl_reg <= p_hl_next;
            p_hh_reg <= p_hh_next;
        end
        if (ld2) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (ld3) begin
            tag_reg <= tag_next;
        end
    end

    // source for a one-place move toward the least recent end; the top takes the new tag
    for (genvar g = 0; g < SLOTS; g++) begin : g_up
        if (g < SLOTS - 1) begin : g_mid
            assign tag_up[g] = tags_reg[g+1];
        end else begin : g_top
            assign tag_up[g] = tag_reg;
        end
    end

    always_comb begin
        lru_full = (occ_reg == OCC_W'(SLOTS));
        for (int j = 0; j < SLOTS; j++) begin
            match[j] = (OCC_W'(j) < occ_reg) && (tags_reg[j] == tag_reg);
        end
        lru_hit = |match;
        for (int j = 0; j < SLOTS; j++) begin
            shifted            = match << (SLOTS - 1 - j);
            at_or_above_hit[j] = |shifted;
        end
        for (int j = 0; j < SLOTS; j++) begin
            tags_next[j] = tags_reg[j];
            if (lru_hit) begin
                if (OCC_W'(j) == occ_reg - OCC_W'(1)) begin
                    tags_next[j] = tag_reg;
                end else if (at_or_above_hit[j] && (OCC_W'(j) < occ_reg)) begin
                    tags_next[j] = tag_up[j];
                end
            end else if (lru_full) begin
                tags_next[j] = tag_up[j];
            end else if (OCC_W'(j) == occ_reg) begin
                tags_next[j] = tag_reg;
            end
        end
        occ_next = (!lru_hit && !lru_full) ? occ_reg + OCC_W'(1) : occ_reg;
        evicted  = (!lru_hit && lru_full) ? tags_reg[0] : '0;
        occ_ext  = OCC_X_W'(occ_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (ld4) begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            for (int j = 0; j < SLOTS; j++) begin
                tags_reg[j] <= tags_next[j];
            end
            m_chunk_index_reg    <= tag_reg;
            m_hit_reg            <= lru_hit;
            m_evict_valid_reg    <= !lru_hit && lru_full;
            m_evicted_index_reg  <= evicted;
            m_resident_count_reg <= occ_ext[clt_pkg::COUNT_W-1:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_chunk_index    = m_chunk_index_reg;
    assign m_hit            = m_hit_reg;
    assign m_evict_valid    = m_evict_valid_reg;
    assign m_evicted_index  = m_evicted_index_reg;
    assign m_resident_count = m_resident_count_reg;

    `CLT_ASSERT_NOW(a_evict_only_on_miss, aclk, aresetn,
                    m_valid_reg && m_evict_valid_reg, !m_hit_reg)
    `CLT_ASSERT_NEXT(a_occ_grows_on_fill, aclk, aresetn,
                     ld4 && !lru_hit && !lru_full, occ_reg == $past(occ_reg) + OCC_W'(1))
    `CLT_ASSERT_NEXT(a_occ_holds_otherwise, aclk, aresetn,
                     !ld4 || lru_hit || lru_full, occ_reg == $past(occ_reg))

endmodule

`default_nettype wire

### dv/chunk_lru_tag_tracker_checker.sv
// Checker for the chunk LRU tag tracker: recency-store predictor and result scoreboard.
module chunk_lru_tag_tracker_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic [clt_pkg::KEY_W-1:0]   s_key,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [clt_pkg::TAG_W-1:0]   m_chunk_index,
    input  wire logic                        m_hit,
    input  wire logic                        m_evict_valid,
    input  wire logic [clt_pkg::TAG_W-1:0]   m_evicted_index,
    input  wire logic [clt_pkg::COUNT_W-1:0] m_resident_count,
    output int                               errors,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PENDING_DEPTH = 16;
    localparam int PENDING_W     = $clog2(PENDING_DEPTH);

    typedef struct packed {
        logic [clt_pkg::TAG_W-1:0]   chunk_index;
        logic                        hit;
        logic                        evict_valid;
        logic [clt_pkg::TAG_W-1:0]   evicted_index;
        logic [clt_pkg::COUNT_W-1:0] resident_count;
    } chunk_result_t;

    logic [clt_pkg::TAG_W-1:0] lru_tags [clt_pkg::SLOTS_DEFAULT];
    int                        occupancy;
    chunk_result_t             pending [PENDING_DEPTH];
    logic [PENDING_W-1:0]      rd_idx;
    logic [PENDING_W-1:0]      wr_idx;
    int                        pending_count;

    task automatic lookup_chunk(input logic [clt_pkg::KEY_W-1:0] key,
                                output chunk_result_t res);
        longint unsigned           quotient;
        logic [clt_pkg::TAG_W-1:0] tag;
        int                        pos;
        quotient = 64'(key) / clt_pkg::CHUNK_SIZE_DEFAULT;
        tag      = quotient[clt_pkg::TAG_W-1:0];
        pos      = -1;
        for (int i = 0; i < occupancy; i++) begin
            if (pos < 0 && lru_tags[i] == tag) begin
                pos = i;
            end
        end
        res.chunk_index   = tag;
        res.hit           = (pos >= 0);
        res.evict_valid   = 1'b0;
        res.evicted_index = '0;
        if (pos >= 0) begin
            for (int j = pos; j + 1 < occupancy; j++) begin
                lru_tags[j] = lru_tags[j + 1];
            end
            lru_tags[occupancy - 1] = tag;
        end else if (occupancy >= clt_pkg::SLOTS_DEFAULT) begin
            res.evict_valid   = 1'b1;
            res.evicted_index = lru_tags[0];
            for (int j = 0; j + 1 < clt_pkg::SLOTS_DEFAULT; j++) begin
                lru_tags[j] = lru_tags[j + 1];
            end
            lru_tags[clt_pkg::SLOTS_DEFAULT - 1] = tag;
        end else begin
            lru_tags[occupancy] = tag;
            occupancy++;
        end
        res.resident_count = clt_pkg::COUNT_W'(occupancy);
    endtask

    task automatic check_field(input string name, input longint unsigned expv,
                               input longint unsigned actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        chunk_result_t exp_r;
        if (!aresetn) begin
            rd_idx        = '0;
            wr_idx        = '0;
            pending_count = 0;
            occupancy     = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_count == 0) begin
                    $display("%0t: unexpected result transaction, actual chunk_index %0d",
                             $time, m_chunk_index);
                    errors++;
                end else begin
                    exp_r         = pending[rd_idx];
                    rd_idx        = rd_idx + PENDING_W'(1);
                    pending_count = pending_count - 1;
                    check_field("chunk_index", exp_r.chunk_index, m_chunk_index);
                    check_field("hit", exp_r.hit, m_hit);
                    check_field("evict_valid", exp_r.evict_valid, m_evict_valid);
                    check_field("evicted_index", exp_r.evicted_index, m_evicted_index);
                    check_field("resident_count", exp_r.resident_count, m_resident_count);
                end
            end
            if (s_valid && s_ready) begin
                lookup_chunk(s_key, exp_r);
                if (pending_count == PENDING_DEPTH) begin
                    $display("%0t: too many transactions in flight, expected at most %0d",
                             $time, PENDING_DEPTH);
                    errors++;
                end else begin
                    pending[wr_idx] = exp_r;
                    wr_idx          = wr_idx + PENDING_W'(1);
                    pending_count   = pending_count + 1;
                end
            end
            outstanding <= pending_count;
        end
    end

endmodule

### dv/tb_chunk_lru_tag_tracker.sv
// Testbench top for the chunk LRU tag tracker: stimulus, receiver stalls and verdict.
module tb_chunk_lru_tag_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MAX_CHUNK      = 64'd4611686018427;
    localparam int              RANDOM_KEYS    = 400;
    localparam int              POOL_SIZE      = 12;
    localparam int              LONG_HOLD      = 80;
    localparam int              DRAIN_CYCLES   = 20;
    localparam int              WATCHDOG_LIMIT = 3000;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } ready_mode_t;

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [clt_pkg::KEY_W-1:0]   s_key   = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [clt_pkg::TAG_W-1:0]   m_chunk_index;
    logic                        m_hit;
    logic                        m_evict_valid;
    logic [clt_pkg::TAG_W-1:0]   m_evicted_index;
    logic [clt_pkg::COUNT_W-1:0] m_resident_count;

    int              errors;
    int              outstanding;
    int              idle_cycles;
    int              burst_left;
    int              hold_requests;
    longint unsigned chunk_pool [POOL_SIZE];

    logic [clt_pkg::KEY_W-1:0] directed_keys [$] = '{
        63'd0, 63'd1999999, 63'd2000000, 63'h7FFF_FFFF_FFFF_FFFF,
        63'd4000000, 63'd6000000, 63'd8000000, 63'd10000000, 63'd12000000,
        63'd0, 63'd14000000, 63'd9999999,
        63'd9223372036854000000, 63'd9223372036854775000,
        63'd2000001, 63'h4000_0000_0000_0000, 63'h5555_5555_5555_5555,
        63'h2AAA_AAAA_AAAA_AAAA, 63'h4000_0000_0000_0000, 63'd12000000
    };

    chunk_lru_tag_tracker i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key            (s_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_chunk_index    (m_chunk_index),
        .m_hit            (m_hit),
        .m_evict_valid    (m_evict_valid),
        .m_evicted_index  (m_evicted_index),
        .m_resident_count (m_resident_count)
    );

    chunk_lru_tag_tracker_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key            (s_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_chunk_index    (m_chunk_index),
        .m_hit            (m_hit),
        .m_evict_valid    (m_evict_valid),
        .m_evicted_index  (m_evicted_index),
        .m_resident_count (m_resident_count),
        .errors           (errors),
        .outstanding      (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint unsigned random_chunk();
        return {$urandom, $urandom} % MAX_CHUNK;
    endfunction

    function automatic logic [clt_pkg::KEY_W-1:0] key_in_chunk(input longint unsigned chunk);
        return clt_pkg::KEY_W'(chunk * clt_pkg::CHUNK_SIZE_DEFAULT
                      + $urandom_range(0, 32'(clt_pkg::CHUNK_SIZE_DEFAULT - 1)));
    endfunction

    task automatic offer_key(input logic [clt_pkg::KEY_W-1:0] k);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_key   <= k;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_all_results();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        ready_mode_t mode;
        int unsigned phase;
        int          holds_served;
        mode         = READY_ALWAYS;
        phase        = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                phase++;
                if (phase % 64 == 0) begin
                    mode = ready_mode_t'($urandom_range(0, 3));
                end
                case (mode)
                    READY_ALWAYS:   m_ready <= 1'b1;
                    READY_MOSTLY:   m_ready <= ($urandom_range(0, 9) < 7);
                    READY_RARELY:   m_ready <= ($urandom_range(0, 3) == 0);
                    default:        m_ready <= (phase % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_chunk_lru_tag_tracker: done, errors");
            $finish;
        end
    end

    initial begin
        logic [clt_pkg::KEY_W-1:0] k;
        for (int i = 0; i < POOL_SIZE; i++) begin
            chunk_pool[i] = (i < POOL_SIZE - 2) ? longint'($urandom_range(0, 30)) : random_chunk();
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_keys[i]) begin
            offer_key(directed_keys[i]);
        end
        wait_all_results();

        for (int n = 0; n < RANDOM_KEYS; n++) begin
            if (n == 100 || n == 300) begin
                hold_requests++;
            end
            if (n == 200) begin
                wait_all_results();
            end
            if ($urandom_range(0, 19) == 0) begin
                chunk_pool[$urandom_range(0, POOL_SIZE - 1)] = random_chunk();
            end
            if ($urandom_range(0, 4) == 0) begin
                k = clt_pkg::KEY_W'({$urandom, $urandom});
            end else begin
                k = key_in_chunk(chunk_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
            offer_key(k);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_chunk_lru_tag_tracker: done, clean");
        end else begin
            $display("tb_chunk_lru_tag_tracker: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/clt_pkg.sv
hw/rtl/chunk_lru_tag_tracker.sv
dv/chunk_lru_tag_tracker_checker.sv
dv/tb_chunk_lru_tag_tracker.sv
